// ===== rtl/ssa_pkg.sv =====
// constants, slot layout and sequencer states for shortest_subarray_sum_at_least
// no dependencies; every other rtl file refers to this package by scoped names
`default_nettype none

package ssa_pkg;

    localparam int MAX_LEN   = 1024;
    localparam int IDX_W     = $clog2(MAX_LEN);
    localparam int POS_W     = $clog2(MAX_LEN + 1);
    localparam int SAMPLE_W  = 16;
    localparam int SUM_W     = 32;
    localparam int OUT_IDX_W = 10;
    localparam int RUN_SUM_W = 26;

    // one deque entry: run start and its sum relative to the running offset
    typedef struct packed {
        logic [IDX_W-1:0] origin;
        logic [SUM_W-1:0] rel_sum;
    } slot_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BACK,
        ST_PUSH,
        ST_FRONT,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

// ===== rtl/ssa_stream_if.sv =====
// valid/ready channel interfaces for the sample input and the result output
// depends on ssa_pkg for field widths
`default_nettype none

interface ssa_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [ssa_pkg::SAMPLE_W-1:0] sample;
    logic                                is_last;

    modport source (output valid, sample, is_last, input ready);
    modport sink (input valid, sample, is_last, output ready);
endinterface

interface ssa_out_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 found;
    logic        [ssa_pkg::OUT_IDX_W-1:0] start_index;
    logic        [ssa_pkg::OUT_IDX_W-1:0] end_index;
    logic signed [ssa_pkg::RUN_SUM_W-1:0] run_sum;
    logic                                 too_long;

    modport source (output valid, found, start_index, end_index, run_sum, too_long,
                    input ready);
    modport sink (input valid, found, start_index, end_index, run_sum, too_long,
                  output ready);
endinterface

`default_nettype wire

// ===== rtl/shortest_subarray_sum_at_least.sv =====
// shortest run with sum at least a threshold, monotonic deque kept in one slot ram
// depends on ssa_pkg and the interfaces in ssa_stream_if
//
//   channel     | dir | handshake        | payload
//   ------------+-----+------------------+-------------------------------------------
//   sample_ch   | in  | valid / ready    | sample, is_last
//   result_ch   | out | valid / ready    | found, start_index, end_index, run_sum,
//               |     |                  | too_long
//   cfg         | in  | cfg_we           | cfg_data (threshold)
//
// a sample beat steps through accept, one ram read-compare per back
// entry examined (b, zero when the deque is empty), the push, and one read-compare
// per front entry examined (f >= 1); a last beat then also loads the result.
// the single-port-read slot ram sets this pace: every compare waits on one ram read.
// reset clears all control state; the slot ram holds no reset value.
// the result register frees the input side; a last beat waits only if the previous
// result is still held.
`default_nettype none

module shortest_subarray_sum_at_least (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_we,
    input  wire logic [ssa_pkg::SUM_W-1:0]    cfg_data,
    ssa_in_if.sink                            sample_ch,
    ssa_out_if.source                         result_ch
);

    localparam logic [ssa_pkg::IDX_W-1:0] LAST_PTR = ssa_pkg::IDX_W'(ssa_pkg::MAX_LEN - 1);
    localparam logic [ssa_pkg::POS_W-1:0] FULL_POS = ssa_pkg::POS_W'(ssa_pkg::MAX_LEN);

    function automatic logic [ssa_pkg::IDX_W-1:0] inc_ptr(input logic [ssa_pkg::IDX_W-1:0] p);
        inc_ptr = (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ssa_pkg::IDX_W-1:0] dec_ptr(input logic [ssa_pkg::IDX_W-1:0] p);
        dec_ptr = (p == '0) ? LAST_PTR : p - 1'b1;
    endfunction

    ssa_pkg::state_t state_reg, state_next;

    logic signed [ssa_pkg::SUM_W-1:0]     threshold_reg;
    logic signed [ssa_pkg::SAMPLE_W-1:0]  sample_reg, sample_next;
    logic                                 last_reg, last_next;
    logic [ssa_pkg::IDX_W-1:0]            head_reg, head_next;
    logic [ssa_pkg::IDX_W-1:0]            tail_reg, tail_next;
    logic [ssa_pkg::POS_W-1:0]            count_reg, count_next;
    logic [ssa_pkg::SUM_W-1:0]            offset_reg, offset_next;
    logic [ssa_pkg::POS_W-1:0]            position_reg, position_next;
    logic [ssa_pkg::IDX_W-1:0]            best_start_reg, best_start_next;
    logic [ssa_pkg::IDX_W-1:0]            best_end_reg, best_end_next;
    logic [ssa_pkg::SUM_W-1:0]            best_sum_reg, best_sum_next;
    logic                                 best_valid_reg, best_valid_next;
    logic                                 overflowed_reg, overflowed_next;

    logic                                 out_valid_reg, out_valid_next;
    logic                                 out_found_reg, out_found_next;
    logic [ssa_pkg::OUT_IDX_W-1:0]        out_start_reg, out_start_next;
    logic [ssa_pkg::OUT_IDX_W-1:0]        out_end_reg, out_end_next;
    logic [ssa_pkg::RUN_SUM_W-1:0]        out_sum_reg, out_sum_next;
    logic                                 out_too_long_reg, out_too_long_next;

    // slot ram and its read-after-write bypass
    ssa_pkg::slot_t                       mem [ssa_pkg::MAX_LEN];
    ssa_pkg::slot_t                       mem_q;
    ssa_pkg::slot_t                       wr_slot;
    ssa_pkg::slot_t                       fwd_slot_reg;
    logic                                 fwd_hit_reg;
    logic                                 mem_we;
    logic [ssa_pkg::IDX_W-1:0]            wr_addr;
    logic [ssa_pkg::IDX_W-1:0]            rd_addr;

    logic                                 result_free;
    ssa_pkg::slot_t                       rd_slot;
    logic signed [ssa_pkg::SUM_W-1:0]     slot_total;
    logic signed [ssa_pkg::SUM_W-1:0]     sample_ext;
    logic signed [ssa_pkg::SUM_W-1:0]     in_sample_ext;
    logic                                 back_pop;
    logic                                 front_pop;
    logic [ssa_pkg::POS_W-1:0]            run_len;
    logic [ssa_pkg::POS_W-1:0]            best_len;

    assign result_free = !out_valid_reg || result_ch.ready;

    assign rd_slot       = fwd_hit_reg ? fwd_slot_reg : mem_q;
    assign slot_total    = rd_slot.rel_sum + offset_reg;
    assign sample_ext    = {{(ssa_pkg::SUM_W - ssa_pkg::SAMPLE_W){sample_reg[ssa_pkg::SAMPLE_W-1]}},
                            sample_reg};
    assign in_sample_ext = {{(ssa_pkg::SUM_W - ssa_pkg::SAMPLE_W)
                             {sample_ch.sample[ssa_pkg::SAMPLE_W-1]}}, sample_ch.sample};
    assign back_pop      = (slot_total <= sample_ext);
    assign front_pop     = (slot_total >= threshold_reg);
    assign run_len       = position_reg - ssa_pkg::POS_W'(rd_slot.origin);
    assign best_len      = ssa_pkg::POS_W'(best_end_reg - best_start_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssa_pkg::ST_IDLE:
            begin
                // ready is high in this state, so valid alone marks the beat
                if (sample_ch.valid)
                begin
                    if (position_reg == FULL_POS)
                        state_next = sample_ch.is_last ? ssa_pkg::ST_FINISH : ssa_pkg::ST_IDLE;
                    else if (count_reg != '0)
                        state_next = ssa_pkg::ST_BACK;
                    else
                        state_next = ssa_pkg::ST_PUSH;
                end
            end
            ssa_pkg::ST_BACK:
            begin
                if (!(back_pop && count_reg != ssa_pkg::POS_W'(1)))
                    state_next = ssa_pkg::ST_PUSH;
            end
            ssa_pkg::ST_PUSH:
                state_next = ssa_pkg::ST_FRONT;
            ssa_pkg::ST_FRONT:
            begin
                if (!(front_pop && count_reg != ssa_pkg::POS_W'(1)))
                    state_next = last_reg ? ssa_pkg::ST_FINISH : ssa_pkg::ST_IDLE;
            end
            ssa_pkg::ST_FINISH:
            begin
                if (result_free)
                    state_next = ssa_pkg::ST_IDLE;
            end
            default:
                state_next = ssa_pkg::ST_IDLE;
        endcase
    end

    // datapath, ram access and handshake outputs
    always_comb
    begin
        sample_next       = sample_reg;
        last_next         = last_reg;
        head_next         = head_reg;
        tail_next         = tail_reg;
        count_next        = count_reg;
        offset_next       = offset_reg;
        position_next     = position_reg;
        best_start_next   = best_start_reg;
        best_end_next     = best_end_reg;
        best_sum_next     = best_sum_reg;
        best_valid_next   = best_valid_reg;
        overflowed_next   = overflowed_reg;
        out_valid_next    = out_valid_reg && !result_ch.ready;
        out_found_next    = out_found_reg;
        out_start_next    = out_start_reg;
        out_end_next      = out_end_reg;
        out_sum_next      = out_sum_reg;
        out_too_long_next = out_too_long_reg;
        mem_we            = 1'b0;
        wr_addr           = tail_reg;
        wr_slot.origin    = position_reg[ssa_pkg::IDX_W-1:0];
        wr_slot.rel_sum   = sample_ext - offset_reg;
        sample_ch.ready   = 1'b0;
        rd_addr           = dec_ptr(tail_reg);

        case (state_reg)
            ssa_pkg::ST_IDLE:
            begin
                sample_ch.ready = 1'b1;
                if (sample_ch.valid)
                begin
                    sample_next = sample_ch.sample;
                    last_next   = sample_ch.is_last;
                    if (position_reg == FULL_POS)
                        overflowed_next = 1'b1;
                    else
                        offset_next = offset_reg + in_sample_ext;
                end
            end
            ssa_pkg::ST_BACK:
            begin
                // entry at the back no larger than the new sample: drop it
                if (back_pop)
                begin
                    tail_next  = dec_ptr(tail_reg);
                    count_next = count_reg - 1'b1;
                end
                rd_addr = dec_ptr(tail_next);
            end
            ssa_pkg::ST_PUSH:
            begin
                mem_we     = 1'b1;
                tail_next  = inc_ptr(tail_reg);
                count_next = count_reg + 1'b1;
                rd_addr    = head_reg;
            end
            ssa_pkg::ST_FRONT:
            begin
                if (front_pop)
                begin
                    head_next  = inc_ptr(head_reg);
                    count_next = count_reg - 1'b1;
                    // strictly shorter only, so the earliest run keeps a tie
                    if (!best_valid_reg || run_len < best_len)
                    begin
                        best_valid_next = 1'b1;
                        best_start_next = rd_slot.origin;
                        best_end_next   = position_reg[ssa_pkg::IDX_W-1:0];
                        best_sum_next   = slot_total;
                    end
                end
                rd_addr = head_next;
                if (!(front_pop && count_reg != ssa_pkg::POS_W'(1)))
                    position_next = position_reg + 1'b1;
            end
            ssa_pkg::ST_FINISH:
            begin
                if (result_free)
                begin
                    out_valid_next    = 1'b1;
                    out_too_long_next = overflowed_reg;
                    if (overflowed_reg || !best_valid_reg)
                    begin
                        out_found_next = 1'b0;
                        out_start_next = '0;
                        out_end_next   = '0;
                        out_sum_next   = '0;
                    end
                    else
                    begin
                        out_found_next = 1'b1;
                        out_start_next = ssa_pkg::OUT_IDX_W'(best_start_reg);
                        out_end_next   = ssa_pkg::OUT_IDX_W'(best_end_reg);
                        out_sum_next   = best_sum_reg[ssa_pkg::RUN_SUM_W-1:0];
                    end
                    head_next       = '0;
                    tail_next       = '0;
                    count_next      = '0;
                    offset_next     = '0;
                    position_next   = '0;
                    best_start_next = '0;
                    best_end_next   = '0;
                    best_sum_next   = '0;
                    best_valid_next = 1'b0;
                    overflowed_next = 1'b0;
                end
            end
            default:
            begin
                sample_ch.ready = 1'b0;
            end
        endcase
    end

    assign result_ch.valid       = out_valid_reg;
    assign result_ch.found       = out_found_reg;
    assign result_ch.start_index = out_start_reg;
    assign result_ch.end_index   = out_end_reg;
    assign result_ch.run_sum     = out_sum_reg;
    assign result_ch.too_long    = out_too_long_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_addr] <= wr_slot;
        mem_q        <= mem[rd_addr];
        fwd_slot_reg <= wr_slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ssa_pkg::ST_IDLE;
            threshold_reg    <= '0;
            fwd_hit_reg      <= 1'b0;
            head_reg         <= '0;
            tail_reg         <= '0;
            count_reg        <= '0;
            offset_reg       <= '0;
            position_reg     <= '0;
            best_start_reg   <= '0;
            best_end_reg     <= '0;
            best_sum_reg     <= '0;
            best_valid_reg   <= 1'b0;
            overflowed_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            if (cfg_we)
                threshold_reg <= cfg_data;
            // a read of the slot being written sees the new data
            fwd_hit_reg      <= mem_we && (wr_addr == rd_addr);
            head_reg         <= head_next;
            tail_reg         <= tail_next;
            count_reg        <= count_next;
            offset_reg       <= offset_next;
            position_reg     <= position_next;
            best_start_reg   <= best_start_next;
            best_end_reg     <= best_end_next;
            best_sum_reg     <= best_sum_next;
            best_valid_reg   <= best_valid_next;
            overflowed_reg   <= overflowed_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg       <= sample_next;
        last_reg         <= last_next;
        out_found_reg    <= out_found_next;
        out_start_reg    <= out_start_next;
        out_end_reg      <= out_end_next;
        out_sum_reg      <= out_sum_next;
        out_too_long_reg <= out_too_long_next;
    end

endmodule

`default_nettype wire
